// ===== sv/allm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allm_pkg
// shared action and status codes, controller command and status structs
// ----------------------------------------------------------------------------
package allm_pkg;

    localparam logic [2:0] ACT_ADD_FIRST = 3'd0;
    localparam logic [2:0] ACT_ADD_AFTER = 3'd1;
    localparam logic [2:0] ACT_ADD_LAST  = 3'd2;
    localparam logic [2:0] ACT_DEL_FIRST = 3'd3;
    localparam logic [2:0] ACT_DEL_AFTER = 3'd4;
    localparam logic [2:0] ACT_DEL_LAST  = 3'd5;
    localparam logic [2:0] ACT_DEL_ALL   = 3'd6;
    localparam logic [2:0] ACT_READ      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;  // capture input beat
    localparam logic [3:0] OP_SCAN_FREE = 4'd2;  // step free search
    localparam logic [3:0] OP_WALK      = 4'd3;  // step pointer walk
    localparam logic [3:0] OP_INS_HEAD  = 4'd4;
    localparam logic [3:0] OP_INS_AFTER = 4'd5;  // after walk pointer
    localparam logic [3:0] OP_REM_HEAD  = 4'd6;
    localparam logic [3:0] OP_REM_AFTER = 4'd7;
    localparam logic [3:0] OP_CLEAR     = 4'd8;
    localparam logic [3:0] OP_ERR       = 4'd9;  // emit error result
    localparam logic [3:0] OP_READ_EMIT = 4'd10; // emit read result
    localparam logic [3:0] OP_WALK_HEAD = 4'd11; // walk pointer to head
    localparam logic [3:0] OP_WALK_POS  = 4'd12; // walk pointer to position
    localparam logic [3:0] OP_CLR_STEP  = 4'd13; // step clear sweep

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] err;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       empty;
        logic       pos_ok;
        logic       pos_at_end;
        logic       free_hit;   // scan slot is free
        logic       scan_done;  // scan index at last slot
        logic       walk_end;   // walk slot is end of list
        logic       next_end;   // successor of walk slot is end of list
        logic       walk_done;  // walk step budget used
        logic       head_end;
        logic       out_busy;
    } t_stat;

endpackage

// ===== sv/allm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allm_ctrl
// sequencer for list actions, drives datapath commands
// ----------------------------------------------------------------------------
module allm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  allm_pkg::t_stat  i_stat,
    output allm_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_FREE = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd.op = allm_pkg::OP_NONE;
        o_cmd.err = allm_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = allm_pkg::OP_LATCH;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                    case (i_stat.action)
                        allm_pkg::ACT_ADD_FIRST, allm_pkg::ACT_ADD_AFTER,
                        allm_pkg::ACT_ADD_LAST: begin
                            if (i_stat.full) begin
                                o_cmd.op = allm_pkg::OP_ERR;
                                o_cmd.err = allm_pkg::ST_FULL;
                                n_state = S_WAIT;
                            end else if (i_stat.action == allm_pkg::ACT_ADD_AFTER
                                         && !i_stat.pos_ok) begin
                                o_cmd.op = allm_pkg::OP_ERR;
                                o_cmd.err = allm_pkg::ST_BAD;
                                n_state = S_WAIT;
                            end else begin
                                o_cmd.op = allm_pkg::OP_SCAN_FREE;
                                n_state = S_FREE;
                            end
                        end
                        allm_pkg::ACT_DEL_ALL: begin
                            o_cmd.op = allm_pkg::OP_CLEAR;
                            n_state = S_EXEC;
                        end
                        default: begin
                            if (i_stat.empty) begin
                                o_cmd.op = allm_pkg::OP_ERR;
                                o_cmd.err = allm_pkg::ST_EMPTY;
                                n_state = S_WAIT;
                            end else if (i_stat.action == allm_pkg::ACT_DEL_FIRST) begin
                                o_cmd.op = allm_pkg::OP_REM_HEAD;
                                n_state = S_WAIT;
                            end else if (i_stat.action == allm_pkg::ACT_DEL_AFTER) begin
                                if (!i_stat.pos_ok || i_stat.pos_at_end) begin
                                    o_cmd.op = allm_pkg::OP_ERR;
                                    o_cmd.err = allm_pkg::ST_BAD;
                                    n_state = S_WAIT;
                                end else begin
                                    o_cmd.op = allm_pkg::OP_WALK_POS;
                                    n_state = S_EXEC;
                                end
                            end else if (i_stat.action == allm_pkg::ACT_DEL_LAST) begin
                                if (i_stat.head_end) begin
                                    o_cmd.op = allm_pkg::OP_REM_HEAD;
                                    n_state = S_WAIT;
                                end else begin
                                    o_cmd.op = allm_pkg::OP_WALK_HEAD;
                                    n_state = S_WALK;
                                end
                            end else begin
                                o_cmd.op = allm_pkg::OP_WALK_HEAD;
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_FREE: begin
                if (i_stat.free_hit || i_stat.scan_done) begin
                    if (i_stat.action == allm_pkg::ACT_ADD_FIRST || i_stat.empty) begin
                        o_cmd.op = allm_pkg::OP_INS_HEAD;
                        n_state = S_WAIT;
                    end else if (i_stat.action == allm_pkg::ACT_ADD_AFTER) begin
                        o_cmd.op = allm_pkg::OP_WALK_POS;
                        n_state = S_EXEC;
                    end else begin
                        o_cmd.op = allm_pkg::OP_WALK_HEAD;
                        n_state = S_WALK;
                    end
                end else begin
                    o_cmd.op = allm_pkg::OP_SCAN_FREE;
                end
            end
            S_WALK: begin
                // add last: stop at tail; delete last: stop before tail
                if (i_stat.action == allm_pkg::ACT_ADD_LAST) begin
                    if (i_stat.walk_end || i_stat.walk_done) begin
                        n_state = S_EXEC;
                    end else begin
                        o_cmd.op = allm_pkg::OP_WALK;
                    end
                end else if (i_stat.next_end || i_stat.walk_done) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.op = allm_pkg::OP_WALK;
                end
            end
            S_EXEC: begin
                if (i_stat.action == allm_pkg::ACT_DEL_ALL) begin
                    if (i_stat.scan_done) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.op = allm_pkg::OP_CLR_STEP;
                    end
                end else if (i_stat.action == allm_pkg::ACT_DEL_AFTER
                             || i_stat.action == allm_pkg::ACT_DEL_LAST) begin
                    o_cmd.op = allm_pkg::OP_REM_AFTER;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.op = allm_pkg::OP_INS_AFTER;
                    n_state = S_WAIT;
                end
            end
            S_READ: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = allm_pkg::OP_READ_EMIT;
                    if (i_stat.walk_end || i_stat.walk_done) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/allm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allm_dp
// link and payload stores, head and count, walk and scan pointers, output beat
// ----------------------------------------------------------------------------
module allm_dp #(
    parameter int SLOT_COUNT   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  allm_pkg::t_cmd            i_cmd,
    output allm_pkg::t_stat           o_stat,
    input  logic [2:0]                i_action,
    input  logic [3:0]                i_position,
    input  logic [31:0]               i_name_word,
    input  logic [31:0]               i_level_word,
    input  logic [31:0]               i_device_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [4:0]                o_element_count,
    output logic [3:0]                o_slot,
    output logic [31:0]               o_out_name,
    output logic [31:0]               o_out_level,
    output logic [31:0]               o_out_device,
    output logic                      o_last
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    // link bits: used, at_end, next
    logic [SLOT_COUNT-1:0] r_used, r_end;
    logic [SW-1:0]         r_next [SLOT_COUNT];
    logic [3*PAYLOAD_BITS-1:0] r_pay [SLOT_COUNT];
    logic [3*PAYLOAD_BITS-1:0] r_rd;

    logic             r_head_valid;
    logic [SW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [2:0]       r_action;
    logic [3:0]       r_pos;
    logic [3*PAYLOAD_BITS-1:0] r_in_pay;
    logic [SW-1:0]    r_scan;
    logic [SW-1:0]    r_walk;
    logic [CW-1:0]    r_steps;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [3:0]       r_slot;
    logic             r_last;
    logic             r_rd_sel;
    logic             r_clr_last;

    logic             pos_in;
    logic [SW-1:0]    pos_s, walk_nx, victim;

    assign pos_in  = ({28'd0, r_pos} < 32'(SLOT_COUNT));
    assign pos_s   = SW'(r_pos);
    assign walk_nx = r_next[r_walk];
    assign victim  = r_next[r_walk];

    always_comb begin
        o_stat.action     = r_action;
        o_stat.full       = (r_count >= CW'(SLOT_COUNT));
        o_stat.empty      = !r_head_valid;
        o_stat.pos_ok     = pos_in && r_used[pos_s];
        o_stat.pos_at_end = r_end[pos_s];
        o_stat.free_hit   = !r_used[r_scan];
        o_stat.scan_done  = (r_scan == SW'(SLOT_COUNT - 1));
        o_stat.walk_end   = r_end[r_walk];
        o_stat.next_end   = r_end[walk_nx];
        o_stat.walk_done  = (r_steps >= CW'(SLOT_COUNT - 1));
        o_stat.head_end   = r_end[r_head];
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.op inside {allm_pkg::OP_ERR, allm_pkg::OP_INS_HEAD,
                                       allm_pkg::OP_INS_AFTER, allm_pkg::OP_REM_HEAD,
                                       allm_pkg::OP_REM_AFTER, allm_pkg::OP_READ_EMIT})
                     || (i_cmd.op == allm_pkg::OP_NONE && r_action == allm_pkg::ACT_DEL_ALL
                         && o_stat.scan_done && r_clr_last)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // clear sweep reached the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_last <= 1'b0;
        end else if (i_cmd.op == allm_pkg::OP_CLEAR) begin
            r_clr_last <= (SLOT_COUNT == 1);
        end else if (i_cmd.op == allm_pkg::OP_CLR_STEP) begin
            r_clr_last <= (r_scan + SW'(1) == SW'(SLOT_COUNT - 1));
        end else begin
            r_clr_last <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_end        <= '0;
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
        end else begin
            case (i_cmd.op)
                allm_pkg::OP_LATCH: begin
                    r_action <= i_action;
                    r_pos    <= i_position;
                    r_in_pay <= {PAYLOAD_BITS'(i_device_word), PAYLOAD_BITS'(i_level_word),
                                 PAYLOAD_BITS'(i_name_word)};
                    r_scan   <= '0;
                end
                allm_pkg::OP_SCAN_FREE: begin
                    if (!r_used[r_scan]) begin
                    end else begin
                        r_scan <= r_scan + SW'(1);
                    end
                end
                allm_pkg::OP_WALK_HEAD: begin
                    r_walk  <= r_head;
                    r_steps <= '0;
                end
                allm_pkg::OP_WALK_POS: begin
                    r_walk <= pos_s;
                end
                allm_pkg::OP_WALK: begin
                    r_walk  <= walk_nx;
                    r_steps <= r_steps + CW'(1);
                end
                allm_pkg::OP_INS_HEAD: begin
                    r_pay[r_scan]  <= r_in_pay;
                    r_used[r_scan] <= 1'b1;
                    r_end[r_scan]  <= !r_head_valid;
                    r_next[r_scan] <= r_head_valid ? r_head : '0;
                    r_head         <= r_scan;
                    r_head_valid   <= 1'b1;
                    r_count        <= r_count + CW'(1);
                    r_status <= allm_pkg::ST_OK;
                    r_slot   <= 4'(r_scan);
                    r_last   <= 1'b1;
                    r_rd_sel <= 1'b0;
                end
                allm_pkg::OP_INS_AFTER: begin
                    r_pay[r_scan]  <= r_in_pay;
                    r_used[r_scan] <= 1'b1;
                    r_end[r_scan]  <= r_end[r_walk];
                    r_next[r_scan] <= r_next[r_walk];
                    r_end[r_walk]  <= 1'b0;
                    r_next[r_walk] <= r_scan;
                    r_count        <= r_count + CW'(1);
                    r_status <= allm_pkg::ST_OK;
                    r_slot   <= 4'(r_scan);
                    r_last   <= 1'b1;
                    r_rd_sel <= 1'b0;
                end
                allm_pkg::OP_REM_HEAD: begin
                    if (r_end[r_head]) begin
                        r_head_valid <= 1'b0;
                        r_head       <= '0;
                    end else begin
                        r_head <= r_next[r_head];
                    end
                    r_used[r_head] <= 1'b0;
                    r_end[r_head]  <= 1'b0;
                    r_next[r_head] <= '0;
                    if (r_count != '0) r_count <= r_count - CW'(1);
                    r_status <= allm_pkg::ST_OK;
                    r_slot   <= 4'(r_head);
                    r_last   <= 1'b1;
                    r_rd_sel <= 1'b0;
                end
                allm_pkg::OP_REM_AFTER: begin
                    r_end[r_walk]  <= r_end[victim];
                    r_next[r_walk] <= r_next[victim];
                    r_used[victim] <= 1'b0;
                    r_end[victim]  <= 1'b0;
                    r_next[victim] <= '0;
                    if (r_count != '0) r_count <= r_count - CW'(1);
                    r_status <= allm_pkg::ST_OK;
                    r_slot   <= 4'(victim);
                    r_last   <= 1'b1;
                    r_rd_sel <= 1'b0;
                end
                allm_pkg::OP_CLEAR: begin
                    r_head_valid <= 1'b0;
                    r_head       <= '0;
                    r_count      <= '0;
                    r_scan       <= '0;
                    r_used[0]    <= 1'b0;
                    r_end[0]     <= 1'b0;
                    r_next[0]    <= '0;
                end
                allm_pkg::OP_CLR_STEP: begin
                    r_used[r_scan + SW'(1)] <= 1'b0;
                    r_end[r_scan + SW'(1)]  <= 1'b0;
                    r_next[r_scan + SW'(1)] <= '0;
                    r_scan     <= r_scan + SW'(1);
                end
                allm_pkg::OP_ERR: begin
                    r_status <= i_cmd.err;
                    r_slot   <= '0;
                    r_last   <= 1'b1;
                    r_rd_sel <= 1'b0;
                end
                allm_pkg::OP_READ_EMIT: begin
                    r_rd     <= r_pay[r_walk];
                    r_rd_sel <= 1'b1;
                    r_status <= allm_pkg::ST_OK;
                    r_slot   <= 4'(r_walk);
                    r_last   <= r_end[r_walk] || (r_steps >= CW'(SLOT_COUNT - 1));
                    r_walk   <= walk_nx;
                    r_steps  <= r_steps + CW'(1);
                end
                default: ;
            endcase
            if (i_cmd.op == allm_pkg::OP_NONE && r_action == allm_pkg::ACT_DEL_ALL
                && o_stat.scan_done && r_clr_last) begin
                r_status <= allm_pkg::ST_OK;
                r_slot   <= '0;
                r_last   <= 1'b1;
                r_rd_sel <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_element_count = 5'(r_count);
    assign o_slot          = r_slot;
    assign o_last          = r_last;
    assign o_out_name   = r_rd_sel ? 32'(r_rd[PW-1:0]) : '0;
    assign o_out_level  = r_rd_sel ? 32'(r_rd[PAYLOAD_BITS+PW-1:PAYLOAD_BITS]) : '0;
    assign o_out_device = r_rd_sel ? 32'(r_rd[2*PAYLOAD_BITS+PW-1:2*PAYLOAD_BITS]) : '0;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOT_COUNT))
        else $error("count above slot count");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_head_valid |-> r_count == '0)
        else $error("empty list with nonzero count");
    a_head_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_valid |-> r_used[r_head])
        else $error("head slot not in use");
    a_beat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_slot) && $stable(r_status))
        else $error("stalled beat changed");

endmodule

// ===== sv/array_linked_list_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager
// singly linked list in a fixed slot pool, one action per input beat
// ----------------------------------------------------------------------------
// With no output stall an action passes through decode and then steps through
// slots: the free slot search steps slot by slot up to the lowest free one,
// add after and delete after also move the walk pointer to the position, add
// last and delete last walk link by link toward the tail, delete all sweeps all
// SLOT_COUNT slots, and read out gives one beat per element per cycle. Add last
// on a list one short of full is the longest action. The next action is
// accepted in the cycle after the last result beat is taken.
module array_linked_list_manager #(
    parameter int SLOT_COUNT   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_position,
    input  logic [31:0] i_name_word,
    input  logic [31:0] i_level_word,
    input  logic [31:0] i_device_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_element_count,
    output logic [3:0]  o_slot,
    output logic [31:0] o_out_name,
    output logic [31:0] o_out_level,
    output logic [31:0] o_out_device,
    output logic        o_last
);

    allm_pkg::t_cmd  cmd;
    allm_pkg::t_stat stat;

    allm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    allm_dp #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_name_word     (i_name_word),
        .i_level_word    (i_level_word),
        .i_device_word   (i_device_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_slot          (o_slot),
        .o_out_name      (o_out_name),
        .o_out_level     (o_out_level),
        .o_out_device    (o_out_device),
        .o_last          (o_last)
    );

endmodule
